@@ src/rdpt_pkg.sv @@
// Shared types and constants of the radial distance point thinning block.
package rdpt_pkg;

    localparam int unsigned ValueW = 32;
    localparam int unsigned CdfW   = 17;
    localparam int unsigned IndexW = 16;
    localparam int unsigned LimW   = 2 * ValueW;
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
    localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

    // Squared limit after reset: 1.0 in Q16.16, squared to Q32.32.
    localparam logic [LimW-1:0] LimSqReset = 64'h0000_0001_0000_0000;

    typedef struct packed {
        logic signed [ValueW-1:0] sample_value;
        logic [CdfW-1:0]          cdf_value;
        logic                     last_point;
    } t_item;

    typedef struct packed {
        logic [IndexW-1:0] kept_index;
        logic              last_result;
    } t_result;

    // Up to two results leave the decision stage per item, first in slot a.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    a;
        t_result    b;
    } t_push;

endpackage

@@ src/rdpt_point_if.sv @@
// Point channel: one curve point per item.
interface rdpt_point_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [rdpt_pkg::ValueW-1:0]      sample_value;
    logic [rdpt_pkg::CdfW-1:0]               cdf_value;
    logic                                    last_point;

    modport source (output valid, output sample_value, output cdf_value,
                    output last_point, input ready);
    modport sink   (input valid, input sample_value, input cdf_value,
                    input last_point, output ready);
endinterface

@@ src/rdpt_kept_if.sv @@
// Result channel: one kept index per item.
interface rdpt_kept_if;
    logic                          valid;
    logic                          ready;
    logic [rdpt_pkg::IndexW-1:0]   kept_index;
    logic                          last_result;

    modport source (output valid, output kept_index, output last_result, input ready);
    modport sink   (input valid, input kept_index, input last_result, output ready);
endinterface

@@ src/radial_distance_point_thinning.sv @@
// Top level of the radial distance point thinning block.
//
// Usage:
//   i_pt carries curve points (sample value Q16.16 signed, cdf Q1.16,
//   last_point marking the end of a curve). o_kept carries the stream
//   positions of kept points; last_result marks the final index of a curve.
//   i_cfg_we/i_cfg_wdata write the distance limit (Q16.16); write it only
//   while the block is idle. The limit is squared on the write.
// Timing:
//   An accepted item is held in the input register and decided from it once
//   the output queue has room for two results; its results are written into
//   the output queue and offered on o_kept from there. One point is taken
//   every cycle while the queue has room for two results. A curve end can
//   produce two results; the output queue drains one per cycle, so the
//   output port sets the long-run rate.
// Reset and stalls:
//   Reset clears the curve state, empties the queue and loads a limit of 1.0.
//   When o_kept stalls, the four-entry queue fills; the decision stage holds
//   once fewer than two slots are free, and i_pt.ready drops behind it.
module radial_distance_point_thinning #(
    parameter int unsigned MAX_POINTS = 65536
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rdpt_pkg::ValueW-1:0]         i_cfg_wdata,
    rdpt_point_if.sink                          i_pt,
    rdpt_kept_if.source                         o_kept
);
    logic [rdpt_pkg::LimW-1:0]  r_lim_sq;
    logic                       r_in_vld, n_in_vld;
    rdpt_pkg::t_item            r_in_item;
    rdpt_pkg::t_push            push;
    rdpt_pkg::t_result          out_data;
    logic                       room2;
    logic                       advance;
    logic                       accept;

    // Square the limit once on the write; comparisons use the square.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_sq <= rdpt_pkg::LimSqReset;
        end else if (i_cfg_we) begin
            r_lim_sq <= {{rdpt_pkg::ValueW{1'b0}}, i_cfg_wdata}
                      * {{rdpt_pkg::ValueW{1'b0}}, i_cfg_wdata};
        end
    end

    // Advance the input register only when the queue can take two results.
    assign advance    = r_in_vld && room2;
    assign i_pt.ready = !r_in_vld || room2;
    assign accept     = i_pt.valid && i_pt.ready;

    always_comb begin
        n_in_vld = r_in_vld;
        if (accept) begin
            n_in_vld = 1'b1;
        end else if (advance) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item.sample_value <= i_pt.sample_value;
            r_in_item.cdf_value    <= i_pt.cdf_value;
            r_in_item.last_point   <= i_pt.last_point;
        end
    end

    rdpt_core #(
        .MAX_POINTS (MAX_POINTS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (advance),
        .i_item   (r_in_item),
        .i_lim_sq (r_lim_sq),
        .o_push   (push)
    );

    rdpt_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_vld   (o_kept.valid),
        .i_rdy   (o_kept.ready),
        .o_data  (out_data)
    );

    assign o_kept.kept_index  = out_data.kept_index;
    assign o_kept.last_result = out_data.last_result;

endmodule

@@ src/rdpt_core.sv @@
// Per-point keep/drop decision and curve state of the thinning block.
module rdpt_core #(
    parameter int unsigned MAX_POINTS = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  rdpt_pkg::t_item             i_item,
    input  logic [rdpt_pkg::LimW-1:0]   i_lim_sq,
    output rdpt_pkg::t_push             o_push
);
    localparam int unsigned CntW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [CntW-1:0] CntLast = CntW'(MAX_POINTS - 1);

    logic [CntW-1:0]                     r_count, n_count;
    logic signed [rdpt_pkg::ValueW-1:0]  r_ref_value, n_ref_value;
    logic [rdpt_pkg::CdfW-1:0]           r_ref_cdf, n_ref_cdf;
    logic [rdpt_pkg::IndexW-1:0]         r_held_index, n_held_index;
    logic                                r_held_valid, n_held_valid;
    logic                                r_held_prev, n_held_prev;

    logic [rdpt_pkg::IndexW-1:0]         idx;
    logic signed [rdpt_pkg::ValueW:0]    diff_v;
    logic [rdpt_pkg::ValueW-1:0]         abs_v;
    logic [rdpt_pkg::CdfW:0]             diff_c;
    logic [rdpt_pkg::CdfW-1:0]           abs_c;
    logic [rdpt_pkg::LimW-1:0]           sq_v;
    logic [2*rdpt_pkg::CdfW-1:0]         sq_c;
    logic [rdpt_pkg::LimW:0]             d_sq;
    logic                                far;
    logic                                near;

    generate
        if (CntW >= rdpt_pkg::IndexW) begin : g_idx_trunc
            assign idx = r_count[rdpt_pkg::IndexW-1:0];
        end else begin : g_idx_ext
            assign idx = {{(rdpt_pkg::IndexW - CntW){1'b0}}, r_count};
        end
    endgenerate

    // Squared distance to the reference, exact.
    always_comb begin
        diff_v = {i_item.sample_value[rdpt_pkg::ValueW-1], i_item.sample_value}
               - {r_ref_value[rdpt_pkg::ValueW-1], r_ref_value};
        abs_v  = diff_v[rdpt_pkg::ValueW] ? (~diff_v[rdpt_pkg::ValueW-1:0] + 1'b1)
                                          : diff_v[rdpt_pkg::ValueW-1:0];
        diff_c = {1'b0, i_item.cdf_value} - {1'b0, r_ref_cdf};
        abs_c  = diff_c[rdpt_pkg::CdfW] ? (~diff_c[rdpt_pkg::CdfW-1:0] + 1'b1)
                                        : diff_c[rdpt_pkg::CdfW-1:0];
        sq_v   = {{rdpt_pkg::ValueW{1'b0}}, abs_v} * {{rdpt_pkg::ValueW{1'b0}}, abs_v};
        sq_c   = {{rdpt_pkg::CdfW{1'b0}}, abs_c} * {{rdpt_pkg::CdfW{1'b0}}, abs_c};
        d_sq   = {1'b0, sq_v} + {{(rdpt_pkg::LimW + 1 - 2*rdpt_pkg::CdfW){1'b0}}, sq_c};
        far    = d_sq > {1'b0, i_lim_sq};
        near   = {d_sq, 4'b0000} < {5'b00000, i_lim_sq};
    end

    always_comb begin
        n_count      = r_count;
        n_ref_value  = r_ref_value;
        n_ref_cdf    = r_ref_cdf;
        n_held_index = r_held_index;
        n_held_valid = r_held_valid;
        n_held_prev  = r_held_prev;
        o_push       = '0;
        if (i_vld) begin
            if (i_item.last_point) begin
                // End of curve: replace, drop or flush the held index.
                if (!r_held_valid || r_held_prev) begin
                    o_push.cnt = 2'd1;
                    o_push.a   = '{kept_index: idx, last_result: 1'b1};
                end else if (!far && near) begin
                    o_push.cnt = 2'd1;
                    o_push.a   = '{kept_index: idx, last_result: 1'b1};
                end else begin
                    o_push.cnt = 2'd2;
                    o_push.a   = '{kept_index: r_held_index, last_result: 1'b0};
                    o_push.b   = '{kept_index: idx, last_result: 1'b1};
                end
                n_count      = '0;
                n_ref_value  = '0;
                n_ref_cdf    = '0;
                n_held_index = '0;
                n_held_valid = 1'b0;
                n_held_prev  = 1'b0;
            end else begin
                if (!r_held_valid || far) begin
                    if (r_held_valid) begin
                        o_push.cnt = 2'd1;
                        o_push.a   = '{kept_index: r_held_index, last_result: 1'b0};
                    end
                    n_held_index = idx;
                    n_held_valid = 1'b1;
                    n_held_prev  = 1'b1;
                    n_ref_value  = i_item.sample_value;
                    n_ref_cdf    = i_item.cdf_value;
                end else begin
                    n_held_prev = 1'b0;
                end
                n_count = (r_count == CntLast) ? '0 : r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_ref_value  <= '0;
            r_ref_cdf    <= '0;
            r_held_index <= '0;
            r_held_valid <= 1'b0;
            r_held_prev  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_ref_value  <= n_ref_value;
            r_ref_cdf    <= n_ref_cdf;
            r_held_index <= n_held_index;
            r_held_valid <= n_held_valid;
            r_held_prev  <= n_held_prev;
        end
    end

endmodule

@@ src/rdpt_out_fifo.sv @@
// Small result queue that takes up to two items per cycle and releases one.
module rdpt_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rdpt_pkg::t_push    i_push,
    output logic               o_room2,
    output logic               o_vld,
    input  logic               i_rdy,
    output rdpt_pkg::t_result  o_data
);
    rdpt_pkg::t_result                  r_mem [rdpt_pkg::FifoDepth];
    logic [rdpt_pkg::FifoPtrW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [rdpt_pkg::FifoPtrW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [rdpt_pkg::FifoCntW-1:0]      r_count, n_count;
    logic [rdpt_pkg::FifoPtrW-1:0]      wr_ptr1;
    logic                               pop;

    assign o_vld   = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_vld && i_rdy;
    assign o_room2 = (r_count <= rdpt_pkg::FifoCntW'(rdpt_pkg::FifoDepth - 2));
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + rdpt_pkg::FifoPtrW'(i_push.cnt);
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + rdpt_pkg::FifoCntW'(i_push.cnt)
                 - rdpt_pkg::FifoCntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.a;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
